/* sv/swm_pkg.sv */
// ============================================================================
// swm_pkg - shared definitions for the sliding window median filter
// Field widths, window limits, cell control types and sequencer states.
// ============================================================================
package swm_pkg;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned MEDIAN_W   = 33;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned MAX_WINDOW = 64;
  localparam int unsigned K_RESET    = 3;

  // Operation broadcast to every cell of the sorted chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_REMOVE,
    OP_INSERT
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_PICK,
    ST_WRITE
  } swm_state_e;

  typedef struct packed {
    cell_op_e                    op;
    logic signed [SAMPLE_W-1:0]  key;
  } cell_ctrl_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  value;
    logic                        lt;     // valid and value below key
    logic                        eq;     // valid and value equal to key
  } cell_link_t;

endpackage

/* sv/swm_cell.sv */
// ============================================================================
// swm_cell - one slot of the sorted window chain
// Holds one value; shifts toward a neighbor on remove or insert.
// ============================================================================
module swm_cell (
  input  logic               clk_i,
  input  swm_pkg::cell_ctrl_t ctrl_i,
  input  logic               valid_i,
  input  swm_pkg::cell_link_t left_i,
  input  swm_pkg::cell_link_t right_i,
  output swm_pkg::cell_link_t link_o
);
  import swm_pkg::*;

  logic signed [SAMPLE_W-1:0] value_q, value_d;
  logic                       take_right;

  // Remove the last instance equal to the key: every cell from there on
  // pulls its right neighbor.
  assign take_right = valid_i && (value_q >= ctrl_i.key) && !right_i.eq;

  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      OP_REMOVE: begin
        if (take_right) begin
          value_d = right_i.value;
        end
      end
      OP_INSERT: begin
        if (!link_o.lt) begin
          value_d = left_i.lt ? ctrl_i.key : left_i.value;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.value = value_q;
  assign link_o.lt    = valid_i && (value_q < ctrl_i.key);
  assign link_o.eq    = valid_i && (value_q == ctrl_i.key);

endmodule

/* sv/swm_ring.sv */
// ============================================================================
// swm_ring - arrival order ring of samples
// One port: read the oldest word and overwrite it with the new one.
// ============================================================================
module swm_ring #(
  parameter int unsigned Depth = swm_pkg::MAX_WINDOW,
  parameter int unsigned AddrW = 6
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AddrW-1:0]             addr_i,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] wdata_i,
  output logic signed [swm_pkg::SAMPLE_W-1:0] rdata_o
);
  import swm_pkg::*;

  logic signed [SAMPLE_W-1:0] mem_q [Depth];
  logic signed [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rdata_q        <= mem_q[addr_i];
      mem_q[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/sliding_window_median.sv */
// ============================================================================
// sliding_window_median - streaming running median over the last K samples
// Keeps a sorted chain of cells plus an arrival ring; emits 2 * median.
// ============================================================================
// Usage:
//   Input words (sample_i, start_new_i, end_of_sequence_i) arrive on a
//   valid/ready channel; results (median_doubled_o, last_o) leave on another.
//   window_size_i is written through its own valid/ready channel while the
//   block is idle, before any waiting input word; a write also empties the
//   window. Zero acts as one, values above MaxWindow saturate.
//   Each word goes through these steps in order: the oldest sample is read
//   from the ring as the word is accepted, it is dropped from the sorted
//   chain, the new sample is inserted, the middle cells are picked and the
//   sum is formed into the output register. The next word is taken only
//   once the previous one has finished its write step. No result comes out
//   until the window holds K samples.
//   The result sits in an output register, so a stalled receiver does not
//   hold up the next word; only the final write step waits for the register
//   to drain. Reset clears the window, restores K = 3 and empties the output.
// ============================================================================
module sliding_window_median #(
  parameter int unsigned MaxWindow = swm_pkg::MAX_WINDOW
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [swm_pkg::CFG_W-1:0]           window_size_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                start_new_i,
  input  logic                                end_of_sequence_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [swm_pkg::MEDIAN_W-1:0] median_doubled_o,
  output logic                                last_o
);
  import swm_pkg::*;

  localparam int unsigned KW     = $clog2(MaxWindow + 1);
  localparam int unsigned PW     = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned KReset = (MaxWindow < K_RESET) ? MaxWindow : K_RESET;

  swm_state_e state_q, state_d;

  logic [KW-1:0] k_q, k_d;
  logic [KW-1:0] fill_q, fill_d;
  logic [PW-1:0] ptr_q, ptr_d;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q;
  logic                       full_q;

  logic signed [SAMPLE_W-1:0] lo_q, hi_q;
  logic signed [SAMPLE_W-1:0] lo_pick, hi_pick;

  logic signed [MEDIAN_W-1:0] med_q;
  logic                       med_last_q;
  logic                       out_valid_q;

  logic                       cfg_take, in_take, out_take, out_load;
  logic                       emit;

  // Effective fill and ring slot for the accepted word
  logic [KW-1:0]              fill_eff;
  logic [PW-1:0]              ptr_eff;
  logic [KW-1:0]              ptr_next;

  logic signed [SAMPLE_W-1:0] old_sample;
  cell_ctrl_t                 ctrl;
  cell_link_t                 links [MaxWindow];
  logic [MaxWindow-1:0]       cell_valid;

  logic [KW-1:0]              lo_idx, hi_idx;

  assign cfg_take = cfg_valid_i && cfg_ready_o;
  assign in_take  = in_valid_i && in_ready_o;
  assign out_take = out_valid_q && out_ready_i;
  assign emit     = (fill_q == k_q);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = ST_REMOVE;
        end
      end
      ST_REMOVE: state_d = ST_INSERT;
      ST_INSERT: state_d = ST_PICK;
      ST_PICK:   state_d = ST_WRITE;
      ST_WRITE: begin
        if (!emit || !out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    out_load    = 1'b0;
    ctrl.op     = OP_HOLD;
    ctrl.key    = sample_q;
    case (state_q)
      ST_IDLE: begin
        // let a pending configuration word go first
        in_ready_o  = !cfg_valid_i;
        cfg_ready_o = 1'b1;
      end
      ST_REMOVE: begin
        // drop the oldest sample only once the window is full
        ctrl.op  = full_q ? OP_REMOVE : OP_HOLD;
        ctrl.key = old_sample;
      end
      ST_INSERT: begin
        ctrl.op  = OP_INSERT;
        ctrl.key = sample_q;
      end
      ST_WRITE: begin
        out_load = emit && (!out_valid_q || out_ready_i);
      end
      default: begin
        ctrl.op = OP_HOLD;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Window bookkeeping
  // --------------------------------------------------------------------------
  always_comb begin
    fill_eff = start_new_i ? '0 : fill_q;
    if (fill_eff > k_q) begin
      fill_eff = '0;
    end
    ptr_eff = start_new_i ? '0 : ptr_q;
    if (KW'(ptr_eff) >= k_q) begin
      ptr_eff = '0;
    end
    ptr_next = KW'(ptr_eff) + KW'(1);
    if (ptr_next >= k_q) begin
      ptr_next = '0;
    end
  end

  always_comb begin
    k_d    = k_q;
    fill_d = fill_q;
    ptr_d  = ptr_q;
    if (cfg_take) begin
      if (window_size_i == '0) begin
        k_d = KW'(1);
      end else if (32'(window_size_i) > 32'(MaxWindow)) begin
        k_d = KW'(MaxWindow);
      end else begin
        k_d = KW'(window_size_i);
      end
      fill_d = '0;
      ptr_d  = '0;
    end else if (in_take) begin
      fill_d = fill_eff;
      ptr_d  = PW'(ptr_next);
    end else if (state_q == ST_REMOVE && full_q) begin
      fill_d = fill_q - KW'(1);
    end else if (state_q == ST_INSERT) begin
      fill_d = fill_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= KW'(KReset);
      fill_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      fill_q  <= fill_d;
      ptr_q   <= ptr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the accepted word for the remove and insert steps
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= sample_i;
      last_q   <= end_of_sequence_i;
      full_q   <= (fill_eff == k_q);
    end
  end

  // --------------------------------------------------------------------------
  // Arrival ring: read the oldest sample, write the new one in its slot
  // --------------------------------------------------------------------------
  swm_ring #(
    .Depth (MaxWindow),
    .AddrW (PW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_take),
    .addr_i  (ptr_eff),
    .wdata_i (sample_i),
    .rdata_o (old_sample)
  );

  // --------------------------------------------------------------------------
  // Sorted chain: cell 0 holds the smallest value
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < MaxWindow; i++) begin : g_cell
    cell_link_t left_link, right_link;

    assign cell_valid[i] = (KW'(i) < fill_q);

    if (i == 0) begin : g_first
      assign left_link = '{value: '0, lt: 1'b1, eq: 1'b0};
    end else begin : g_left
      assign left_link = links[i-1];
    end

    if (i == MaxWindow - 1) begin : g_last
      assign right_link = '{value: '0, lt: 1'b0, eq: 1'b0};
    end else begin : g_right
      assign right_link = links[i+1];
    end

    swm_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .valid_i (cell_valid[i]),
      .left_i  (left_link),
      .right_i (right_link),
      .link_o  (links[i])
    );
  end

  // --------------------------------------------------------------------------
  // Middle pick: lower and upper middle cells coincide when K is odd
  // --------------------------------------------------------------------------
  assign lo_idx = (k_q - KW'(1)) >> 1;
  assign hi_idx = k_q >> 1;

  always_comb begin
    lo_pick = '0;
    hi_pick = '0;
    for (int unsigned i = 0; i < MaxWindow; i++) begin
      if (KW'(i) == lo_idx) begin
        lo_pick = lo_pick | links[i].value;
      end
      if (KW'(i) == hi_idx) begin
        hi_pick = hi_pick | links[i].value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PICK) begin
      lo_q <= lo_pick;
      hi_q <= hi_pick;
    end
    if (out_load) begin
      med_q      <= MEDIAN_W'(lo_q) + MEDIAN_W'(hi_q);
      med_last_q <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = med_q;
  assign last_o           = med_last_q;

endmodule

/* sim/sliding_window_median_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// sliding_window_median_test - running median filter testbench
// Streams signed samples through the filter across several window sizes and
// checks every doubled median and its end flag against a sorted-window
// predictor. Both channels idle and stall at random, and two long receiver
// hold-offs force the block to back up its input.
// ============================================================================
module sliding_window_median_test;

  localparam int unsigned IDLE_PCT      = 21;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned HOLD_AT_A     = 60;
  localparam int unsigned HOLD_AT_B     = 700;
  localparam int unsigned QUIET_PHASE   = 4;      // phase run with no idling
  localparam int unsigned NUM_PHASES    = 11;
  localparam longint     TIMEOUT_NS    = 3_000_000;
  localparam int unsigned RING_AW       = $clog2(swm_pkg::MAX_WINDOW);

  localparam logic signed [swm_pkg::SAMPLE_W-1:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [swm_pkg::SAMPLE_W-1:0] S_MIN = 32'sh80000000;

  // One input word and one result word
  typedef struct {
    logic signed [swm_pkg::SAMPLE_W-1:0] sample;
    logic                                start_new;
    logic                                eos;
  } swm_word_t;

  typedef struct {
    logic signed [swm_pkg::MEDIAN_W-1:0] doubled;
    logic                                last;
  } median_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                       cfg_valid   = 1'b0;
  logic [swm_pkg::CFG_W-1:0]  window_size = '0;
  logic                       in_valid    = 1'b0;
  swm_word_t                  in_word     = '{sample: '0, start_new: 1'b0, eos: 1'b0};
  logic                       out_ready   = 1'b0;

  logic                                cfg_ready_o;
  logic                                in_ready_o;
  logic                                out_valid_o;
  logic signed [swm_pkg::MEDIAN_W-1:0] median_doubled_o;
  logic                                last_o;

  // Words waiting for the driver, medians waiting for the monitor
  swm_word_t pending_words[$];
  median_t   expected_medians[$];

  // Predictor copy of the filter: window length, sorted copy, arrival ring
  logic [swm_pkg::CFG_W-1:0]           window_k = swm_pkg::CFG_W'(swm_pkg::K_RESET);
  logic signed [swm_pkg::SAMPLE_W-1:0] sorted_vals[$];
  logic signed [swm_pkg::SAMPLE_W-1:0] arrival_ring [swm_pkg::MAX_WINDOW];
  int unsigned                         ring_ptr = 0;

  int unsigned errors       = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left    = 0;
  int unsigned idle_pct     = IDLE_PCT;

  sliding_window_median u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .window_size_i     (window_size),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .sample_i          (in_word.sample),
    .start_new_i       (in_word.start_new),
    .end_of_sequence_i (in_word.eos),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .median_doubled_o  (median_doubled_o),
    .last_o            (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Advance the predicted window by one word. Return 1 with the doubled
  // median once the window holds K samples, else 0.
  function automatic bit advance_window(input swm_word_t w, output median_t m);
    int unsigned k;
    int unsigned pos;
    int unsigned lo;
    int unsigned hi;
    // Zero acts as a window of one, anything past the maximum saturates
    if (window_k == 0) k = 1;
    else if (window_k > swm_pkg::MAX_WINDOW) k = swm_pkg::MAX_WINDOW;
    else k = 32'(window_k);
    if (w.start_new) begin
      sorted_vals.delete();
      ring_ptr = 0;
    end
    if (ring_ptr >= k) ring_ptr = 0;
    // Full window: drop one copy of the oldest sample from the sorted copy
    if (sorted_vals.size() == k) begin
      for (pos = 0; pos < sorted_vals.size(); pos++) begin
        if (sorted_vals[pos] == arrival_ring[RING_AW'(ring_ptr)]) begin
          sorted_vals.delete(pos);
          break;
        end
      end
    end
    arrival_ring[RING_AW'(ring_ptr)] = w.sample;
    pos = 0;
    while (pos < sorted_vals.size() && sorted_vals[pos] < w.sample) pos++;
    sorted_vals.insert(pos, w.sample);
    ring_ptr = (ring_ptr + 1 >= k) ? 0 : ring_ptr + 1;
    m.doubled = '0;
    m.last    = w.eos;
    if (sorted_vals.size() < k) return 1'b0;
    // Odd K picks the middle twice, even K sums the two middle entries
    lo = (k - 1) / 2;
    hi = k / 2;
    m.doubled = {sorted_vals[lo][swm_pkg::SAMPLE_W-1], sorted_vals[lo]} +
                {sorted_vals[hi][swm_pkg::SAMPLE_W-1], sorted_vals[hi]};
    return 1'b1;
  endfunction

  function automatic logic signed [swm_pkg::SAMPLE_W-1:0] pick_sample();
    logic signed [swm_pkg::SAMPLE_W-1:0] v;
    case ($urandom_range(9))
      0:       v = S_MAX - $urandom_range(3);
      1:       v = S_MIN + $urandom_range(3);
      // a narrow band gives plenty of equal values inside one window
      2, 3, 4: v = $signed($urandom_range(8)) - 4;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic push_word(input logic signed [swm_pkg::SAMPLE_W-1:0] s,
                           input logic st, input logic eos);
    pending_words.insert(pending_words.size(), '{sample: s, start_new: st, eos: eos});
  endtask

  // Wait until every queued word is taken and every median is back, then
  // let the block settle. Flag medians that never show up.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    while ((pending_words.size() != 0 || in_valid || expected_medians.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_medians.size() != 0) begin
      $display("%0t: %0d expected medians never arrived", $time, expected_medians.size());
      errors++;
      expected_medians.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the window length while the block is idle; a write empties the window
  task automatic write_window(input logic [swm_pkg::CFG_W-1:0] k);
    cfg_valid   <= 1'b1;
    window_size <= k;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    window_k = k;
    sorted_vals.delete();
    ring_ptr = 0;
  endtask

  // Driver: hold each word until it is taken, then offer the next or idle
  always @(posedge clk_i) begin : drive_words
    median_t r;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        if (advance_window(in_word, r)) expected_medians.insert(expected_medians.size(), r);
      end
      if (!in_valid || in_ready_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each median word with the oldest expectation and
  // drive ready, holding off for a long stretch twice during the run
  always @(posedge clk_i) begin : watch_medians
    median_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (expected_medians.size() == 0) begin
          $display("%0t: unexpected median %0d last %0b", $time, median_doubled_o, last_o);
          errors++;
        end else begin
          e = expected_medians.pop_front();
          if (median_doubled_o !== e.doubled) begin
            $display("%0t: median_doubled expected %0d actual %0d",
                     $time, e.doubled, median_doubled_o);
            errors++;
          end
          if (last_o !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, last_o);
            errors++;
          end
        end
        if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin
    int unsigned ph;
    int unsigned k_eff;
    int unsigned n;
    int unsigned len;
    int unsigned j;
    bit          fresh;
    logic [swm_pkg::CFG_W-1:0] k;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset window of three
    push_word(S_MAX, 1'b1, 1'b0);
    push_word(S_MIN, 1'b0, 1'b0);
    push_word(0,     1'b0, 1'b1);   // first full window, marked last
    push_word(-1,    1'b0, 1'b0);   // keep the window after the end mark
    push_word(S_MAX, 1'b0, 1'b0);
    push_word(S_MAX, 1'b0, 1'b0);
    push_word(S_MAX, 1'b0, 1'b1);   // largest positive median
    push_word(5,     1'b1, 1'b1);   // end mark on a window not yet full
    push_word(5,     1'b0, 1'b0);
    push_word(5,     1'b0, 1'b0);   // all equal
    push_word(S_MIN, 1'b1, 1'b0);
    push_word(S_MIN, 1'b0, 1'b0);
    push_word(S_MIN, 1'b0, 1'b1);   // most negative median
    push_word(7,     1'b0, 1'b0);
    push_word(-7,    1'b0, 1'b0);
    push_word(7,     1'b0, 1'b0);
    drain();

    // Even window: sums of the two middle entries, no start flag so the
    // write itself must have emptied the window
    write_window(2);
    push_word(S_MAX, 1'b0, 1'b0);
    push_word(S_MAX, 1'b0, 1'b1);
    push_word(S_MIN, 1'b0, 1'b0);
    push_word(S_MIN, 1'b0, 1'b0);
    push_word(3,     1'b0, 1'b0);
    push_word(4,     1'b0, 1'b1);   // odd sum keeps the half bit
    drain();

    // Random phases over a spread of window lengths, extremes included
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       k = 1;
        1:       k = 0;
        2:       k = 64;
        3:       k = 127;
        4:       k = 5;
        5:       k = 4;
        6:       k = 2;
        7:       k = 3;
        8:       k = 8;
        9:       k = 65;
        default: k = 7;
      endcase
      write_window(k);
      idle_pct = (ph == QUIET_PHASE) ? 0 : IDLE_PCT;
      if (k == 0) k_eff = 1;
      else if (k > swm_pkg::MAX_WINDOW) k_eff = swm_pkg::MAX_WINDOW;
      else k_eff = 32'(k);
      n = (k_eff >= 32) ? 130 : 160;
      while (n > 0) begin
        if ($urandom_range(9) == 0) begin
          // noise: short bursts with random start and end flags
          len = $urandom_range(6, 1);
          if (len > n) len = n;
          repeat (len) push_word(pick_sample(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          // well-formed sequence, long enough to fill the window unless the phase runs out of words
          len = k_eff + $urandom_range(k_eff + 8);
          if (len > n) len = n;
          fresh = ($urandom_range(4) != 0);
          for (j = 0; j < len; j++) push_word(pick_sample(), fresh && j == 0, j == len - 1);
        end
        n -= len;
      end
      drain();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
